/* hw/rtl/gfla_pkg.sv */
// shared types, codes and default polynomials for the gf(2^m) log/antilog unit
`default_nettype none

package gfla_pkg;

  localparam int MAX_DEGREE_DEF = 16;
  localparam int DATA_W         = 16;
  localparam int DEGREE_W       = 5;
  localparam int POLY_W         = 17;
  localparam int ADDR_W         = 3;

  localparam logic [DEGREE_W-1:0] DEGREE_RST = 5'd8;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_POW = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_POLY   = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic [1:0]        status;
  } out_t;

  function automatic logic [POLY_W-1:0] default_poly(input logic [DEGREE_W-1:0] m);
    logic [POLY_W-1:0] p;
    unique case (m)
      5'd0:    p = 17'h00003;
      5'd1:    p = 17'h00003;
      5'd2:    p = 17'h00007;
      5'd3:    p = 17'h0000b;
      5'd4:    p = 17'h00013;
      5'd5:    p = 17'h00025;
      5'd6:    p = 17'h00043;
      5'd7:    p = 17'h00089;
      5'd8:    p = 17'h0011d;
      5'd9:    p = 17'h00211;
      5'd10:   p = 17'h00409;
      5'd11:   p = 17'h00805;
      5'd12:   p = 17'h01053;
      5'd13:   p = 17'h0201b;
      5'd14:   p = 17'h04443;
      5'd15:   p = 17'h08003;
      5'd16:   p = 17'h1100b;
      default: p = 17'h00003;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gf2m_log_antilog_arith.sv */
// top level of the gf(2^m) multiply, divide and power unit with log/antilog tables
`default_nettype none

// Multiplies, divides and raises elements of GF(2^m), m from 1 to MAX_DEGREE, through a log
// table and an antilog table held in on-chip memories. After reset and after every register
// write the tables are rebuilt from the degree and polynomial registers (a fill pass over the
// antilog table that also clears the log table, a pass that links each element to its log, a
// fix-up step) and in_ready stays low throughout. After that the unit takes one item per cycle
// while the output does not stall; each result passes an input register, the dual-port log
// read, the log sum, difference or product, a remainder unit mod 2^m-1 that retires four
// dividend bits per stage, and the registered antilog read that drives the output. A stall on
// the output fills empty stages before it holds the input.
module gf2m_log_antilog_arith #(
  parameter int MAX_DEGREE = gfla_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gfla_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gfla_pkg::out_t                     out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gfla_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW    = MAX_DEGREE;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = AW + gfla_pkg::DATA_W;
  localparam int RSTEP = 4;
  localparam int RST   = (DW + RSTEP - 1) / RSTEP;
  localparam int DP    = RST * RSTEP;
  localparam int NS    = RST + 4;

  typedef enum logic [1:0] {B_IDLE, B_FILL, B_LINK, B_FIX} build_t;

  typedef struct packed {
    logic [1:0] status;
    logic       one;
    logic       use_tbl;
  } side_t;

  // configuration
  logic [gfla_pkg::DEGREE_W-1:0] degree_r;
  logic [gfla_pkg::POLY_W-1:0]   poly_r;
  logic                          cfg_wr;
  logic [gfla_pkg::DEGREE_W-1:0] m_eff;
  logic [gfla_pkg::POLY_W-1:0]   poly_sel;
  logic [AW:0]                   one_sh;
  logic [AW-1:0]                 mask;
  logic [AW-1:0]                 top;
  logic [AW-1:0]                 low;
  logic [gfla_pkg::DATA_W-1:0]   mask16;

  // table build
  build_t        bst_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] lfsr_r;
  logic [AW-1:0] v_step;
  logic          log_we;
  logic [AW-1:0] log_wa;
  logic [AW-1:0] log_wd;
  logic          alog_we;

  logic [AW-1:0] log_mem  [DEPTH];
  logic [AW-1:0] alog_mem [DEPTH];

  // pipeline
  logic [NS:1]                 vld_r;
  logic [NS+1:1]               adv;
  gfla_pkg::in_t               s1_r;
  logic [1:0]                  op2_r;
  logic [gfla_pkg::DATA_W-1:0] b2_r;
  logic [AW-1:0]               la_r;
  logic [AW-1:0]               lb_r;
  side_t                       side_nxt;
  side_t                       side_r [2:NS];
  logic [DP-1:0]               dvd_in;
  logic [DP-1:0]               dvd3_r;
  logic [AW-1:0]               rin     [RST];
  logic [DP-1:0]               din     [RST];
  logic [AW-1:0]               rem_nxt [RST];
  logic [DP-1:0]               dsh_nxt [RST];
  logic [AW-1:0]               rem_r   [RST];
  logic [DP-1:0]               dvd_r   [RST];
  logic [AW-1:0]               al_r;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= gfla_pkg::DEGREE_RST;
      poly_r   <= '0;
    end else if (cfg_wr) begin
      if (paddr[gfla_pkg::ADDR_W-1] == gfla_pkg::REG_POLY) begin
        poly_r <= pwdata[gfla_pkg::POLY_W-1:0];
      end else begin
        degree_r <= pwdata[gfla_pkg::DEGREE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[gfla_pkg::ADDR_W-1] == gfla_pkg::REG_POLY) begin
      prdata = 32'(poly_r);
    end else begin
      prdata = 32'(degree_r);
    end
  end

  // field size from the degree register, clamped to the supported range, and the polynomial and masks derived from it
  always_comb begin
    if (degree_r == '0) begin
      m_eff = gfla_pkg::DEGREE_W'(1);
    end else if (degree_r > gfla_pkg::DEGREE_W'(MAX_DEGREE)) begin
      m_eff = gfla_pkg::DEGREE_W'(MAX_DEGREE);
    end else begin
      m_eff = degree_r;
    end
    poly_sel = (poly_r == '0) ? gfla_pkg::default_poly(m_eff) : poly_r;
    one_sh   = (AW+1)'(1) << m_eff;
    mask     = one_sh[AW-1:0] - AW'(1);
    top      = mask ^ (mask >> 1);
    low      = poly_sel[AW-1:0] & mask;
    mask16   = gfla_pkg::DATA_W'(mask);
  end

  assign v_step = ((lfsr_r << 1) & mask) ^ ((|(lfsr_r & top)) ? low : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r  <= B_FILL;
      cnt_r  <= '0;
      lfsr_r <= AW'(1);
    end else if (cfg_wr) begin
      bst_r  <= B_FILL;
      cnt_r  <= '0;
      lfsr_r <= AW'(1);
    end else begin
      unique case (bst_r)
        B_IDLE: begin
        end
        B_FILL: begin
          if (cnt_r == mask) begin
            bst_r  <= B_LINK;
            cnt_r  <= AW'(1);
            lfsr_r <= AW'(1);
          end else begin
            cnt_r  <= cnt_r + AW'(1);
            lfsr_r <= v_step;
          end
        end
        B_LINK: begin
          cnt_r  <= cnt_r + AW'(1);
          lfsr_r <= v_step;
          if (cnt_r == mask) begin
            bst_r <= B_FIX;
          end
        end
        B_FIX: begin
          bst_r <= B_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    log_we  = 1'b0;
    log_wa  = AW'(1);
    log_wd  = '0;
    alog_we = 1'b0;
    unique case (bst_r)
      B_IDLE: begin
      end
      B_FILL: begin
        log_we  = 1'b1;
        log_wa  = cnt_r;
        alog_we = 1'b1;
      end
      B_LINK: begin
        log_we = 1'b1;
        log_wa = v_step;
        log_wd = cnt_r;
      end
      B_FIX: begin
        log_we = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_wa] <= log_wd;
    end
    if (adv[2]) begin
      la_r <= log_mem[s1_r.operand_a[AW-1:0]];
      lb_r <= log_mem[s1_r.operand_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (alog_we) begin
      alog_mem[cnt_r] <= lfsr_r;
    end
    if (adv[NS]) begin
      al_r <= alog_mem[rem_r[RST-1]];
    end
  end

  // stall chain: a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1] && (bst_r == B_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid && in_ready;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // range, zero and divide checks on the registered transfer
  always_comb begin
    logic a_oor;
    logic b_oor;
    logic a_zero;
    logic b_zero;
    a_oor  = (s1_r.operand_a & ~mask16) != '0;
    b_oor  = (s1_r.operand_b & ~mask16) != '0;
    a_zero = s1_r.operand_a == '0;
    b_zero = s1_r.operand_b == '0;
    side_nxt = '{status: gfla_pkg::ST_OK, one: 1'b0, use_tbl: 1'b0};
    if (s1_r.operation == gfla_pkg::OP_MUL || s1_r.operation == gfla_pkg::OP_DIV) begin
      if (a_oor || b_oor) begin
        side_nxt.status = gfla_pkg::ST_RANGE;
      end else if (s1_r.operation == gfla_pkg::OP_DIV && b_zero) begin
        side_nxt.status = gfla_pkg::ST_DIV_ZERO;
      end else begin
        side_nxt.use_tbl = !a_zero && !b_zero;
      end
    end else if (s1_r.operation == gfla_pkg::OP_POW) begin
      if (a_oor) begin
        side_nxt.status = gfla_pkg::ST_RANGE;
      end else if (a_zero) begin
        side_nxt.one = b_zero;
      end else begin
        side_nxt.use_tbl = 1'b1;
      end
    end
  end

  // exponent before reduction mod 2^m-1
  always_comb begin
    unique case (op2_r)
      gfla_pkg::OP_MUL: dvd_in = DP'(la_r) + DP'(lb_r);
      gfla_pkg::OP_DIV: dvd_in = DP'(la_r) + DP'(mask) - DP'(lb_r);
      default:          dvd_in = DP'(la_r) * DP'(b2_r);
    endcase
  end

  assign rin[0] = '0;
  assign din[0] = dvd3_r;
  for (genvar j = 1; j < RST; j++) begin : g_link
    assign rin[j] = rem_r[j-1];
    assign din[j] = dvd_r[j-1];
  end

  // restoring remainder, msb first, four bits per stage
  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    logic [DP-1:0] d;
    for (int j = 0; j < RST; j++) begin
      r = rin[j];
      d = din[j];
      for (int s = 0; s < RSTEP; s++) begin
        t = {r, d[DP-1]};
        d = d << 1;
        if (t >= {1'b0, mask}) begin
          t = t - {1'b0, mask};
        end
        r = t[AW-1:0];
      end
      rem_nxt[j] = r;
      dsh_nxt[j] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_r <= in_data;
    end
    if (adv[2]) begin
      op2_r     <= s1_r.operation;
      b2_r      <= s1_r.operand_b;
      side_r[2] <= side_nxt;
    end
    if (adv[3]) begin
      dvd3_r    <= dvd_in;
      side_r[3] <= side_r[2];
    end
    for (int j = 0; j < RST; j++) begin
      if (adv[4+j]) begin
        rem_r[j]    <= rem_nxt[j];
        dvd_r[j]    <= dsh_nxt[j];
        side_r[4+j] <= side_r[3+j];
      end
    end
    if (adv[NS]) begin
      side_r[NS] <= side_r[NS-1];
    end
  end

  assign out_valid       = vld_r[NS];
  assign out_data.result = side_r[NS].use_tbl ? gfla_pkg::DATA_W'(al_r)
                                              : gfla_pkg::DATA_W'(side_r[NS].one);
  assign out_data.status = side_r[NS].status;

endmodule

`default_nettype wire

/* test/gf2m_log_antilog_arith_monitor.sv */
// watches the field unit's ports, predicts each result and flags mismatches
module gf2m_log_antilog_arith_monitor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire gfla_pkg::in_t                 in_data,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire gfla_pkg::out_t                out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic                          pready,
  input  wire logic [gfla_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output int                                 pending,
  output int                                 fail_count
);
  import gfla_pkg::*;

  localparam logic [POLY_W-1:0] STD_POLY [0:16] = '{
    17'h00003, 17'h00003, 17'h00007, 17'h0000b, 17'h00013, 17'h00025,
    17'h00043, 17'h00089, 17'h0011d, 17'h00211, 17'h00409, 17'h00805,
    17'h01053, 17'h0201b, 17'h04443, 17'h08003, 17'h1100b
  };

  logic [DEGREE_W-1:0] degree_reg;
  logic [POLY_W-1:0]   poly_reg;
  logic [DATA_W-1:0]   alpha_pow [0:65535];
  logic [DATA_W-1:0]   alpha_log [0:65535];
  out_t                pending_results [$];

  function automatic int unsigned field_bits();
    if (degree_reg == 0) return 1;
    if (degree_reg > MAX_DEGREE_DEF) return MAX_DEGREE_DEF;
    return degree_reg;
  endfunction

  function automatic void build_tables();
    int unsigned m, size, mask, low, v, carry;
    m = field_bits();
    size = 1 << m;
    mask = size - 1;
    low = ((poly_reg == 0) ? STD_POLY[m] : poly_reg) & mask;
    v = 1;
    for (int unsigned i = 0; i < size; i++) alpha_log[i] = '0;
    alpha_pow[0] = 1;
    for (int unsigned i = 1; i < size; i++) begin
      carry = (v >> (m - 1)) & 1;
      v = ((v << 1) & mask) ^ (carry ? low : 0);
      alpha_pow[i] = v[DATA_W-1:0];
      alpha_log[v & mask] = i[DATA_W-1:0];
    end
    alpha_log[1 & mask] = '0;
    alpha_log[0] = '0;
  endfunction

  function automatic out_t gf_compute(in_t item);
    out_t r;
    int unsigned size, q, la, lb;
    longint unsigned prod;
    r.result = '0;
    r.status = ST_OK;
    size = 1 << field_bits();
    q = size - 1;
    case (item.operation)
      OP_MUL, OP_DIV: begin
        if (item.operand_a >= size || item.operand_b >= size) begin
          r.status = ST_RANGE;
        end else if (item.operation == OP_DIV && item.operand_b == 0) begin
          r.status = ST_DIV_ZERO;
        end else if (item.operand_a != 0 && item.operand_b != 0) begin
          la = alpha_log[item.operand_a];
          lb = alpha_log[item.operand_b];
          if (item.operation == OP_MUL) r.result = alpha_pow[(la + lb) % q];
          else r.result = alpha_pow[(la + q - lb) % q];
        end
      end
      OP_POW: begin
        if (item.operand_a >= size) begin
          r.status = ST_RANGE;
        end else if (item.operand_a == 0) begin
          r.result = (item.operand_b == 0) ? 1 : 0;
        end else begin
          prod = longint'(alpha_log[item.operand_a]) * longint'(item.operand_b);
          r.result = alpha_pow[prod % q];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      degree_reg = DEGREE_RST;
      poly_reg = '0;
      build_tables();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_DEGREE, 2'b00}) begin
          degree_reg = pwdata[DEGREE_W-1:0];
          build_tables();
        end else if (paddr == {REG_POLY, 2'b00}) begin
          poly_reg = pwdata[POLY_W-1:0];
          build_tables();
        end
      end
      if (in_valid && in_ready) pending_results.push_back(gf_compute(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result %h status %0d with no transfer outstanding", $time,
                   out_data.result, out_data.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.result !== want.result || out_data.status !== want.status) begin
            $display("%0t: expected result %h status %0d, got result %h status %0d", $time,
                     want.result, want.status, out_data.result, out_data.status);
            fail_count++;
          end
        end
      end
    end
    pending <= pending_results.size();
  end

endmodule

/* test/gf2m_log_antilog_arith_tb.sv */
// stimulus, clock, reset and verdict for the gf(2^m) log/antilog arithmetic unit
module gf2m_log_antilog_arith_tb;
  import gfla_pkg::*;

  localparam logic [1:0] OP_NONE        = 2'd3;
  localparam int         LONG_HOLD      = 400;
  localparam int         WATCHDOG_LIMIT = 600000;
  localparam int         PHASE_ITEMS    = 130;
  localparam int         N_PHASES       = 12;
  localparam int         N_FIXED        = 10;

  localparam logic [DEGREE_W-1:0] PH_DEGREE [0:N_FIXED-1] = '{
    5'd1, 5'd2, 5'd4, 5'd0, 5'd31, 5'd5, 5'd16, 5'd3, 5'd12, 5'd8
  };
  localparam logic [POLY_W-1:0] PH_POLY [0:N_FIXED-1] = '{
    17'h00000, 17'h00000, 17'h00013, 17'h1ffff, 17'h00000,
    17'h0003f, 17'h0100b, 17'h00008, 17'h00000, 17'h0011d
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  pending;
  int                  fail_count;
  bit                  steady;

  gf2m_log_antilog_arith dut (.*);

  gf2m_log_antilog_arith_monitor mon (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned field_bits(logic [DEGREE_W-1:0] deg);
    if (deg == 0) return 1;
    if (deg > MAX_DEGREE_DEF) return MAX_DEGREE_DEF;
    return deg;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DATA_W-1:0] pick_elem(int unsigned size);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 14) return 1;
    if (r < 20) return size - 1;
    if (r < 28) return (size < 65536) ? $urandom_range(size, 65535) : $urandom_range(0, 65535);
    return $urandom_range(0, size - 1);
  endfunction

  task automatic send_op(logic [1:0] op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    in_t item;
    int  gap;
    item.operation = op;
    item.operand_a = a;
    item.operand_b = b;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int unsigned m, int count);
    int unsigned size;
    int          r;
    logic [1:0]  op;
    logic [DATA_W-1:0] a, b;
    size = 1 << m;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 33) op = OP_MUL;
      else if (r < 63) op = OP_DIV;
      else if (r < 95) op = OP_POW;
      else op = OP_NONE;
      a = pick_elem(size);
      if (op == OP_POW && $urandom_range(0, 1) == 1) b = $urandom_range(0, 65535);
      else b = pick_elem(size);
      send_op(op, a, b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // table rebuild holds in_ready low once the write lands
  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    repeat (3) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // order the writes so that, unless the previous field was full size, a full-size rebuild happens only once per field
  task automatic set_field(logic [DEGREE_W-1:0] deg, logic [POLY_W-1:0] poly);
    drain();
    if (field_bits(deg) == MAX_DEGREE_DEF) begin
      write_reg(REG_POLY, poly);
      write_reg(REG_DEGREE, deg);
    end else begin
      write_reg(REG_DEGREE, deg);
      write_reg(REG_POLY, poly);
    end
  endtask

  initial begin
    int run, gap, seen;
    bit held;
    seen = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 48);
      repeat (run) begin
        @(posedge clk);
        if (out_valid && out_ready) seen++;
      end
      if (!held && seen >= 100) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("gf2m_log_antilog_arith: mismatch");
    $finish;
  end

  initial begin
    logic [DEGREE_W-1:0] deg;
    logic [POLY_W-1:0]   poly;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // power-on field, m = 8
    send_op(OP_MUL, 16'd0, 16'd5);
    send_op(OP_MUL, 16'd5, 16'd0);
    send_op(OP_MUL, 16'd1, 16'd1);
    send_op(OP_MUL, 16'd255, 16'd255);
    send_op(OP_MUL, 16'd2, 16'd128);
    send_op(OP_MUL, 16'hffff, 16'd1);
    send_op(OP_DIV, 16'd7, 16'd0);
    send_op(OP_DIV, 16'd0, 16'd0);
    send_op(OP_DIV, 16'd0, 16'd3);
    send_op(OP_DIV, 16'd255, 16'd3);
    send_op(OP_DIV, 16'd256, 16'd3);
    send_op(OP_DIV, 16'd3, 16'd256);
    send_op(OP_DIV, 16'd300, 16'd0);
    send_op(OP_POW, 16'd0, 16'd0);
    send_op(OP_POW, 16'd0, 16'd5);
    send_op(OP_POW, 16'd0, 16'hffff);
    send_op(OP_POW, 16'd2, 16'hffff);
    send_op(OP_POW, 16'd255, 16'd255);
    send_op(OP_POW, 16'd3, 16'd1);
    send_op(OP_POW, 16'd256, 16'd2);
    send_op(OP_NONE, 16'hffff, 16'hffff);
    send_op(OP_NONE, 16'd0, 16'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < N_FIXED) begin
        deg = PH_DEGREE[p];
        poly = PH_POLY[p];
      end else begin
        deg = $urandom_range(1, 11);
        poly = $urandom_range(0, 17'h1ffff);
      end
      set_field(deg, poly);
      steady = ($urandom_range(0, 3) == 0);
      send_random(field_bits(deg), PHASE_ITEMS);
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("gf2m_log_antilog_arith: match");
    end else begin
      $display("gf2m_log_antilog_arith: mismatch");
    end
    $finish;
  end

endmodule

/* gf2m_log_antilog_arith.f */
hw/rtl/gfla_pkg.sv
hw/rtl/gf2m_log_antilog_arith.sv
test/gf2m_log_antilog_arith_monitor.sv
test/gf2m_log_antilog_arith_tb.sv
